// File: hw/rtl/ordered_list_with_key_delete_unit_assert.svh
// Assertion macros shared by the ordered list unit.
`ifndef ORDERED_LIST_WITH_KEY_DELETE_UNIT_ASSERT_SVH
`define ORDERED_LIST_WITH_KEY_DELETE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define OLKD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OLKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define OLKD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define OLKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/olkd_pkg.sv
package olkd_pkg;

   localparam int MODE_WIDTH    = 2;
   localparam int IN_KEY_WIDTH  = 32;
   localparam int STATUS_WIDTH  = 2;
   localparam int OUT_KEY_WIDTH = 32;
   localparam int COUNT_WIDTH   = 5;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_APPEND      = 2'd0,
      MODE_DELETE_KEY  = 2'd1,
      MODE_DELETE_HEAD = 2'd2,
      MODE_DELETE_TAIL = 2'd3
   } mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;
      logic       fetch_head;
      logic       fetch_tail;
      logic       search_step;
      logic       alloc_fresh;
      logic       alloc_pop;
      logic       alloc_load;
      logic       append;
      logic       unlink;
      logic       result_set;
      status_type result_status;
      logic       rsp_load;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      mode_type mode;
      logic     empty;
      logic     full;
      logic     fresh_avail;
      logic     key_match;
      logic     search_last;
   } dp_status_type;

endpackage

// File: hw/rtl/olkd_if.sv
interface olkd_req_if import olkd_pkg::*; ();
   logic                           valid;
   logic                           ready;
   mode_type                       mode;
   logic signed [IN_KEY_WIDTH-1:0] key;

   modport source (output valid, output mode, output key, input ready);
   modport sink   (input valid, input mode, input key, output ready);
endinterface

interface olkd_rsp_if import olkd_pkg::*; ();
   logic                            valid;
   logic                            ready;
   status_type                      status;
   logic signed [OUT_KEY_WIDTH-1:0] removed_key;
   logic [COUNT_WIDTH-1:0]          entry_count;

   modport source (output valid, output status, output removed_key, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input removed_key, input entry_count,
                   output ready);
endinterface

// File: hw/rtl/olkd_datapath.sv
`include "ordered_list_with_key_delete_unit_assert.svh"

module olkd_datapath import olkd_pkg::*; #(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ctrl_cmd_type                    cmd,
   output dp_status_type                   status,
   input  mode_type                        req_mode,
   input  logic signed [IN_KEY_WIDTH-1:0]  req_key,
   output status_type                      rsp_status,
   output logic signed [OUT_KEY_WIDTH-1:0] rsp_removed_key,
   output logic [COUNT_WIDTH-1:0]          rsp_entry_count
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int OCC_W = $clog2(CAPACITY + 1);

   // slot storage
   logic [KEY_WIDTH-1:0] key_mem_ff  [CAPACITY];
   logic [IDX_W-1:0]     next_mem_ff [CAPACITY];
   logic [IDX_W-1:0]     prev_mem_ff [CAPACITY];
   logic [IDX_W-1:0]     free_mem_ff [CAPACITY];   // stack of released slots

   mode_type             mode_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_rd_ff;
   logic [IDX_W-1:0]     next_rd_ff, prev_rd_ff, rd_addr_ff, free_rd_ff, slot_ff;
   logic [IDX_W-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [OCC_W-1:0]     occ_ff, occ_in, hwm_ff, hwm_in, sp_ff, sp_in, seen_ff;
   logic [OCC_W-1:0]     sp_dec;

   status_type                result_status_ff, rsp_status_ff;
   logic [OUT_KEY_WIDTH-1:0]  result_key_ff, rsp_key_ff;
   logic [COUNT_WIDTH-1:0]    rsp_count_ff;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 unlink_last, unlink_head, unlink_tail, unlink_mid;
   logic                 next_we, prev_we;
   logic [IDX_W-1:0]     next_waddr, next_wdata, prev_waddr, prev_wdata;

   assign status.mode        = mode_ff;
   assign status.empty       = (occ_ff == '0);
   assign status.full        = (occ_ff == OCC_W'(CAPACITY));
   assign status.fresh_avail = (hwm_ff != OCC_W'(CAPACITY));
   assign status.key_match   = (key_rd_ff == key_ff);
   assign status.search_last = ((seen_ff + 1'b1) == occ_ff);

   assign rd_en  = cmd.fetch_head | cmd.fetch_tail | cmd.search_step;
   assign sp_dec = sp_ff - 1'b1;

   always_comb begin
      priority if (cmd.fetch_head) begin
         rd_addr = head_ff;
      end else if (cmd.fetch_tail) begin
         rd_addr = tail_ff;
      end else begin
         rd_addr = next_rd_ff;   // walk forward
      end
   end

   assign unlink_last = (occ_ff == OCC_W'(1));
   assign unlink_head = (rd_addr_ff == head_ff);
   assign unlink_tail = (rd_addr_ff == tail_ff);
   assign unlink_mid  = !unlink_last && !unlink_head && !unlink_tail;

   // link write ports: append hooks the new slot on, unlink splices around a middle slot
   always_comb begin
      next_we    = 1'b0;
      next_waddr = tail_ff;
      next_wdata = slot_ff;
      prev_we    = 1'b0;
      prev_waddr = slot_ff;
      prev_wdata = status.empty ? slot_ff : tail_ff;
      if (cmd.append) begin
         next_we = !status.empty;
         prev_we = 1'b1;
      end else if (cmd.unlink && unlink_mid) begin
         next_we    = 1'b1;
         next_waddr = prev_rd_ff;
         next_wdata = next_rd_ff;
         prev_we    = 1'b1;
         prev_waddr = next_rd_ff;
         prev_wdata = prev_rd_ff;
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      hwm_in  = hwm_ff;
      sp_in   = sp_ff;
      if (cmd.alloc_fresh) begin
         hwm_in = hwm_ff + 1'b1;
      end
      if (cmd.alloc_pop) begin
         sp_in = sp_dec;
      end
      if (cmd.append) begin
         tail_in = slot_ff;
         if (status.empty) begin
            head_in = slot_ff;
         end
         occ_in = occ_ff + 1'b1;
      end
      if (cmd.unlink) begin
         sp_in  = sp_ff + 1'b1;
         occ_in = occ_ff - 1'b1;
         priority if (unlink_last) begin
            head_in = '0;
            tail_in = '0;
         end else if (unlink_head) begin
            head_in = next_rd_ff;
         end else if (unlink_tail) begin
            tail_in = prev_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
         hwm_ff  <= '0;
         sp_ff   <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         hwm_ff  <= hwm_in;
         sp_ff   <= sp_in;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         key_mem_ff[slot_ff] <= key_ff;
      end
      if (next_we) begin
         next_mem_ff[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem_ff[prev_waddr] <= prev_wdata;
      end
      if (cmd.unlink) begin
         free_mem_ff[sp_ff[IDX_W-1:0]] <= rd_addr_ff;
      end
      if (rd_en) begin
         key_rd_ff  <= key_mem_ff[rd_addr];
         next_rd_ff <= next_mem_ff[rd_addr];
         prev_rd_ff <= prev_mem_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (cmd.alloc_pop) begin
         free_rd_ff <= free_mem_ff[sp_dec[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         key_ff  <= KEY_WIDTH'(req_key);
      end
      if (cmd.fetch_head) begin
         seen_ff <= '0;
      end else if (cmd.search_step) begin
         seen_ff <= seen_ff + 1'b1;
      end
      if (cmd.alloc_fresh) begin
         slot_ff <= hwm_ff[IDX_W-1:0];
      end else if (cmd.alloc_load) begin
         slot_ff <= free_rd_ff;
      end
      if (cmd.result_set) begin
         result_status_ff <= cmd.result_status;
         result_key_ff    <= cmd.unlink ? OUT_KEY_WIDTH'(key_rd_ff) : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= result_status_ff;
         rsp_key_ff    <= result_key_ff;
         rsp_count_ff  <= COUNT_WIDTH'(occ_ff);
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_removed_key = rsp_key_ff;
   assign rsp_entry_count = rsp_count_ff;

   // a slot is taken but not yet on the list while alloc_load / append run
   `OLKD_ASSERT_IMPLY(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(CAPACITY), "occupancy above capacity")
   `OLKD_ASSERT_IMPLY(a_slot_accounting, clock, reset, !cmd.alloc_load && !cmd.append, ({1'b0, sp_ff} + {1'b0, occ_ff}) == {1'b0, hwm_ff}, "free stack and list disagree on used slots")
   `OLKD_ASSERT_NEXT(a_unlink_count, clock, reset, cmd.unlink, occ_ff == ($past(occ_ff) - 1'b1), "unlink did not drop the count by one")

endmodule

// File: hw/rtl/olkd_controller.sv
`include "ordered_list_with_key_delete_unit_assert.svh"

module olkd_controller import olkd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DISPATCH = 7'b0000010,
      ST_ALLOC    = 7'b0000100,
      ST_APPEND   = 7'b0001000,
      ST_SEARCH   = 7'b0010000,
      ST_UNLINK   = 7'b0100000,
      ST_RESULT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.mode == MODE_APPEND) begin
               if (status.full) begin
                  cmd.result_set    = 1'b1;
                  cmd.result_status = STATUS_FULL;
                  state_in          = ST_RESULT;
               end else if (status.fresh_avail) begin
                  cmd.alloc_fresh = 1'b1;
                  state_in        = ST_APPEND;
               end else begin
                  cmd.alloc_pop = 1'b1;
                  state_in      = ST_ALLOC;
               end
            end else if (status.empty) begin
               cmd.result_set    = 1'b1;
               cmd.result_status = STATUS_EMPTY;
               state_in          = ST_RESULT;
            end else if (status.mode == MODE_DELETE_KEY) begin
               cmd.fetch_head = 1'b1;
               state_in       = ST_SEARCH;
            end else if (status.mode == MODE_DELETE_HEAD) begin
               cmd.fetch_head = 1'b1;
               state_in       = ST_UNLINK;
            end else begin
               cmd.fetch_tail = 1'b1;
               state_in       = ST_UNLINK;
            end
         end
         ST_ALLOC: begin
            cmd.alloc_load = 1'b1;
            state_in       = ST_APPEND;
         end
         ST_APPEND: begin
            cmd.append        = 1'b1;
            cmd.result_set    = 1'b1;
            cmd.result_status = STATUS_DONE;
            state_in          = ST_RESULT;
         end
         ST_SEARCH: begin
            if (status.key_match) begin
               state_in = ST_UNLINK;
            end else if (status.search_last) begin
               cmd.result_set    = 1'b1;
               cmd.result_status = STATUS_NOT_FOUND;
               state_in          = ST_RESULT;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_UNLINK: begin
            cmd.unlink        = 1'b1;
            cmd.result_set    = 1'b1;
            cmd.result_status = STATUS_DONE;
            state_in          = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `OLKD_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && req_ready, state_ff == ST_DISPATCH, "accepted transfer not dispatched")
   `OLKD_ASSERT_NEXT(a_search_continues, clock, reset, (state_ff == ST_SEARCH) && !status.key_match && !status.search_last, state_ff == ST_SEARCH, "search left early")
   `OLKD_ASSERT_NEXT(a_result_held, clock, reset, (state_ff == ST_RESULT) && rsp_valid_ff && !rsp_ready, (state_ff == ST_RESULT) && rsp_valid_ff, "pending result overwritten")

endmodule

// File: hw/rtl/ordered_list_with_key_delete_unit.sv
// Ordered key list: holds up to CAPACITY keys in arrival order as a doubly
// linked list over slot memories. Each req transfer carries a mode (append at
// tail, delete the oldest entry equal to key, delete head, delete tail) and
// yields exactly one rsp transfer with status (done, full, not found, empty),
// the removed key (zero when nothing was removed) and the entry count after
// the operation. Keys are stored and compared on their low KEY_WIDTH bits.
// One item is in work at a time. Refused operations go straight from dispatch
// to the result; append allocates a fresh slot, or, once every slot has been
// handed out, recycles a released slot from the free stack through the ALLOC
// state; delete head or tail fetches that entry and unlinks it; delete by key
// walks the list from the head, passing at most CAPACITY - 1 entries before a
// match, or every entry on a miss; the one-entry-per-cycle walk over the key
// and link memories sets the delete-by-key time. req is ready again the cycle
// after the result is loaded. A new req transfer is taken while the previous
// result still waits on rsp; the next result then holds in the unit until
// that one is taken. No reset sweep: unused slots are handed out by a
// high-water count, freed ones from a stack.
module ordered_list_with_key_delete_unit import olkd_pkg::*; #(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   olkd_req_if.sink   req_bus,
   olkd_rsp_if.source rsp_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // sequencing and handshakes
   olkd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   // list memories, pointers, counters and the result register
   olkd_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (dp_status),
      .req_mode        (req_bus.mode),
      .req_key         (req_bus.key),
      .rsp_status      (rsp_bus.status),
      .rsp_removed_key (rsp_bus.removed_key),
      .rsp_entry_count (rsp_bus.entry_count)
   );

endmodule

// File: dv/key_list_checker.sv
module key_list_checker import olkd_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic clock,
   input  logic reset,
   olkd_req_if  req_mon,
   olkd_rsp_if  rsp_mon,
   output int   fail_count,
   output int   results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type                      status;
      logic signed [OUT_KEY_WIDTH-1:0] removed_key;
      logic [COUNT_WIDTH-1:0]          entry_count;
   } list_result_type;

   // keys held by the list, oldest first
   logic signed [IN_KEY_WIDTH-1:0] mirror_keys[$];
   list_result_type                owed_results[$];

   function automatic list_result_type apply_list_op(mode_type mode,
                                                     logic signed [IN_KEY_WIDTH-1:0] key);
      list_result_type res;
      int              hit;
      res.status      = STATUS_DONE;
      res.removed_key = '0;
      hit             = -1;
      if (mode == MODE_APPEND) begin
         if (mirror_keys.size() >= CAPACITY) res.status = STATUS_FULL;
         else mirror_keys.push_back(key);
      end else if (mirror_keys.size() == 0) begin
         res.status = STATUS_EMPTY;
      end else if (mode == MODE_DELETE_KEY) begin
         // oldest match wins
         for (int i = 0; i < mirror_keys.size(); i++)
            if (hit < 0 && mirror_keys[i] == key) hit = i;
         if (hit < 0) begin
            res.status = STATUS_NOT_FOUND;
         end else begin
            res.removed_key = mirror_keys[hit];
            mirror_keys.delete(hit);
         end
      end else if (mode == MODE_DELETE_HEAD) begin
         res.removed_key = mirror_keys.pop_front();
      end else begin
         res.removed_key = mirror_keys.pop_back();
      end
      res.entry_count = COUNT_WIDTH'(mirror_keys.size());
      return res;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         mirror_keys.delete();
         owed_results.delete();
         fail_count <= 0;
      end else begin
         // result side first: a result never belongs to a same-edge request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               $error("result transfer with nothing outstanding");
               errs++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_mon.status);
                  errs++;
               end
               if (rsp_mon.removed_key !== want.removed_key) begin
                  $error("removed_key: expected %0d actual %0d",
                         want.removed_key, rsp_mon.removed_key);
                  errs++;
               end
               if (rsp_mon.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d actual %0d",
                         want.entry_count, rsp_mon.entry_count);
                  errs++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            owed_results.push_back(apply_list_op(req_mon.mode, req_mon.key));
         fail_count <= fail_count + errs;
      end
      results_owed <= owed_results.size();
   end

endmodule

// File: dv/tb.sv
module tb import olkd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 16;
   localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
   localparam int DRAIN_CYCLES = 40;    // outlasts the longest key walk
   localparam int PHASE_ITEMS  = 400;
   localparam int BURST_ITEMS  = 48;
   localparam int POOL_SIZE    = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int results_owed;
   int quiet_cycles;

   logic signed [IN_KEY_WIDTH-1:0] key_pool[POOL_SIZE];

   olkd_req_if req_bus ();
   olkd_rsp_if rsp_bus ();

   ordered_list_with_key_delete_unit #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (IN_KEY_WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   key_list_checker #(
      .CAPACITY (CAPACITY)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: any transfer on either channel clears the count
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request transfer. Random gaps first, then hold valid until taken.
   // Valid gets a single nonblocking write per edge, so back-to-back
   // transfers keep it high.
   task automatic send_op(input mode_type mode, input logic signed [IN_KEY_WIDTH-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= mode;
      req_bus.key   <= key;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Mostly pooled keys so that delete by key finds matches and duplicates
   // pile up; the rest spans the whole 32-bit range.
   function automatic logic signed [IN_KEY_WIDTH-1:0] pick_key();
      if ($urandom_range(99) < 70) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // Fill bursts push the list toward full, drain bursts toward empty.
   function automatic mode_type pick_mode(input logic filling);
      int roll;
      roll = $urandom_range(99);
      if (filling) begin
         if (roll < 65) return MODE_APPEND;
         if (roll < 85) return MODE_DELETE_KEY;
         if (roll < 93) return MODE_DELETE_HEAD;
         return MODE_DELETE_TAIL;
      end
      if (roll < 25) return MODE_APPEND;
      if (roll < 65) return MODE_DELETE_KEY;
      if (roll < 83) return MODE_DELETE_HEAD;
      return MODE_DELETE_TAIL;
   endfunction

   task automatic run_random_phase(input int sender_idle, input int receiver_idle);
      mode_type mode;
      logic     filling;
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      filling = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % BURST_ITEMS == BURST_ITEMS - 1) filling = !filling;
         mode = pick_mode(filling);
         if (mode == MODE_APPEND || mode == MODE_DELETE_KEY) send_op(mode, pick_key());
         else send_op(mode, $urandom);
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.mode  <= MODE_APPEND;
      req_bus.key   <= '0;
      send_idle_pct = 15;
      recv_idle_pct = 46;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // deletes on an empty list, every delete flavor
      send_op(MODE_DELETE_HEAD, 32'sd0);
      send_op(MODE_DELETE_TAIL, -32'sd1);
      send_op(MODE_DELETE_KEY,  32'sd0);
      // extreme keys
      send_op(MODE_APPEND, 32'sh8000_0000);
      send_op(MODE_APPEND, 32'sh7fff_ffff);
      send_op(MODE_APPEND, 32'sd0);
      send_op(MODE_APPEND, -32'sd1);
      // miss, then unlink middle, tail, head by key
      send_op(MODE_DELETE_KEY, 32'sd7);
      send_op(MODE_DELETE_KEY, 32'sd0);
      send_op(MODE_DELETE_KEY, -32'sd1);
      send_op(MODE_DELETE_KEY, 32'sh8000_0000);
      // last remaining entry goes, list back to empty
      send_op(MODE_DELETE_HEAD, 32'sh7fff_ffff);
      // fill to capacity with a duplicate key, then refused append
      for (int i = 0; i < CAPACITY; i++)
         send_op(MODE_APPEND, (i % 4 == 1) ? 32'sh5a5a_a5a5 : IN_KEY_WIDTH'(i));
      send_op(MODE_APPEND, 32'sh1234_5678);
      send_op(MODE_DELETE_TAIL, 32'sd0);

      run_random_phase(15, 46);
      run_random_phase(46, 15);
      run_random_phase(0, 0);
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && results_owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
